>>> rtl/core/lozd_pkg.sv
// shared widths, constants, register codes and the cosine/sine rom contents
`default_nettype none

package lozd_pkg;

   // scan geometry
   localparam int BEAMS      = 1081;
   localparam int FIRST_BEAM = 80;
   localparam int END_BEAM   = 1001;

   // field widths
   localparam int RANGE_W  = 16;
   localparam int CFG_W    = 16;
   localparam int POS_W    = 18;
   localparam int AX_W     = POS_W + 1;
   localparam int TRIG_W   = 16;
   localparam int OFF_W    = 9;
   localparam int CNT_W    = $clog2(BEAMS + 1);
   localparam int ADDR_W   = $clog2(BEAMS);
   localparam int CSR_IDX_W = 2;

   // stream word widths, padded to whole bytes
   localparam int REQ_TDATA_W = ((RANGE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((2 * OFF_W + 7) / 8) * 8;

   // offset rules in mm
   localparam int OFFSET_LIMIT = 200;
   localparam int ESCAPE_MM    = 600;
   localparam int NEAR_MM      = 10;

   // exact reciprocals: floor(m/5) for m < 2^22, floor(m/10) for m < 2^18
   localparam int MX_W        = 20;
   localparam int MY_W        = 18;
   localparam int DIV5_MUL    = 838861;
   localparam int DIV5_SHIFT  = 22;
   localparam int DIV10_MUL   = 209716;
   localparam int DIV10_SHIFT = 21;
   localparam int PX_W        = MX_W + 20;
   localparam int PY_W        = MY_W + 18;

   // result buffer
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   // reset values of the configuration registers
   localparam logic [CFG_W-1:0] HALF_WIDTH_RST = CFG_W'(300);
   localparam logic [CFG_W-1:0] DEPTH_RST      = CFG_W'(450);
   localparam logic [CFG_W-1:0] RANGE_MIN_RST  = CFG_W'(0);
   localparam logic [CFG_W-1:0] RANGE_MAX_RST  = CFG_W'(30000);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WIDTH = 2'd0,
      CSR_DEPTH      = 2'd1,
      CSR_RANGE_MIN  = 2'd2,
      CSR_RANGE_MAX  = 2'd3
   } csr_index_type;

   // angle constants in q30 radians
   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned ANG_DEN     = 4 * (BEAMS - 1);
   localparam longint unsigned ANG_HALF    = ANG_DEN / 2;

   // rom word: {negated sine, cosine}, both q1.15
   typedef logic [2*TRIG_W-1:0] trig_tab_type [BEAMS];

   // q30 to q15, rounded half up and limited to 0..32767
   function automatic longint q30_to_q15(longint v);
      longint q;
      if (v < 0) begin
         q = 0;
      end else begin
         q = (v + 16384) >>> 15;
         if (q > 32767) q = 32767;
      end
      return q;
   endfunction

   // one rom word for beam i
   function automatic logic [2*TRIG_W-1:0] trig_entry(int i);
      longint          n;
      longint unsigned m;
      longint unsigned a;
      longint unsigned ts;
      longint unsigned tc;
      longint          ss;
      longint          cc;
      longint          sq;
      longint          cq;
      longint          nsin;
      longint          cosv;
      logic            neg;
      logic            flip;
      n    = longint'(3 * (BEAMS - 1)) - longint'(6) * longint'(i);
      neg  = (n < 0);
      m    = neg ? longint'(-n) : longint'(n);
      a    = (PI_Q30 * m + ANG_HALF) / ANG_DEN;
      flip = 1'b0;
      if (a > PI_Q30) a = PI_Q30;
      if (a > HALF_PI_Q30) begin
         a    = PI_Q30 - a;
         flip = 1'b1;
      end
      // eight-term taylor series with truncating steps
      ts = a;
      tc = ONE_Q30;
      ss = longint'(a);
      cc = longint'(ONE_Q30);
      for (int k = 1; k <= 7; k++) begin
         ts = (ts * a) >> 30;
         ts = (ts * a) >> 30;
         tc = (tc * a) >> 30;
         tc = (tc * a) >> 30;
         case (k)
            1: begin ts = ts / 6;   tc = tc / 2;   end
            2: begin ts = ts / 20;  tc = tc / 12;  end
            3: begin ts = ts / 42;  tc = tc / 30;  end
            4: begin ts = ts / 72;  tc = tc / 56;  end
            5: begin ts = ts / 110; tc = tc / 90;  end
            6: begin ts = ts / 156; tc = tc / 132; end
            7: begin ts = ts / 210; tc = tc / 182; end
            default: begin ts = ts; tc = tc; end
         endcase
         if ((k % 2) == 1) begin
            ss = ss - longint'(ts);
            cc = cc - longint'(tc);
         end else begin
            ss = ss + longint'(ts);
            cc = cc + longint'(tc);
         end
      end
      sq   = q30_to_q15(ss);
      cq   = q30_to_q15(cc);
      nsin = neg ? sq : -sq;
      cosv = flip ? -cq : cq;
      return {nsin[TRIG_W-1:0], cosv[TRIG_W-1:0]};
   endfunction

   function automatic trig_tab_type build_trig_tab();
      trig_tab_type tab;
      for (int i = 0; i < BEAMS; i++) begin
         tab[i] = trig_entry(i);
      end
      return tab;
   endfunction

   localparam trig_tab_type TRIG_TAB = build_trig_tab();

endpackage

`default_nettype wire

>>> rtl/core/lidar_obstacle_zone_detector_core.sv
// lidar obstacle zone detector: beam rotation, zone tracking and offset output
//
// req channel: one word per lidar beam in scan order, range in mm in
// req_tdata, req_tlast marks the final beam of a scan. rsp channel: one word
// per scan, sent after the final beam, carrying the forward and sideways
// avoidance offsets. csr channel: register writes, always ready, to be used
// between scans or while no result is pending.
// Throughput is one beam per cycle while req_tready is high. The cosine/sine
// rom read and the multiplies, the tracking update, the offset math, the
// scaling and the reciprocal multiplies sit in registered stages ahead of
// the result buffer.
// Results collect in a four-word buffer. req_tready drops only while four
// scans have ended whose results are not yet taken; beams keep flowing
// while the receiver stalls otherwise.
// Reset loads the register defaults, clears the beam counter, the pipeline
// valids and the buffer; the tracked obstacle values are reloaded from the
// registers on the first beam of every scan.
`default_nettype none

module lidar_obstacle_zone_detector_core (
   input  wire                                   clock,
   input  wire                                   reset,
   // req_tdata: range_mm [15:0]
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [lozd_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire                                   req_tlast,
   // rsp_tdata: offset_x_mm [8:0], offset_y_mm [17:9], zero pad above
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [lozd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // register write channel
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [lozd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [lozd_pkg::CFG_W-1:0]            csr_wdata
);

   localparam int POS_W  = lozd_pkg::POS_W;
   localparam int AX_W   = lozd_pkg::AX_W;
   localparam int CFG_W  = lozd_pkg::CFG_W;
   localparam int TRIG_W = lozd_pkg::TRIG_W;
   localparam int OFF_W  = lozd_pkg::OFF_W;
   localparam int CNT_W  = lozd_pkg::CNT_W;
   localparam int PTR_W  = lozd_pkg::FIFO_PTR_W;
   localparam int MUL_W  = lozd_pkg::RANGE_W + 1 + TRIG_W;

   // configuration registers
   logic [CFG_W-1:0] half_width_ff;
   logic [CFG_W-1:0] depth_ff;
   logic [CFG_W-1:0] range_min_ff;
   logic [CFG_W-1:0] range_max_ff;

   // front end
   logic                       req_accept;
   logic                       rsp_accept;
   logic [CNT_W-1:0]           beam_cnt_ff;
   logic [CNT_W-1:0]           beam_cnt_in;
   logic [lozd_pkg::ADDR_W-1:0] rom_addr;
   logic                       in_window;
   logic                       in_range;

   // stage 1: range and rom word
   logic                       p1_valid_ff;
   logic                       p1_last_ff;
   logic                       p1_first_ff;
   logic                       p1_use_ff;
   logic [lozd_pkg::RANGE_W-1:0] p1_range_ff;
   logic [2*TRIG_W-1:0]        trig_ff;
   logic signed [MUL_W-1:0]    mul_x;
   logic signed [MUL_W-1:0]    mul_y;

   // stage 2: rotated point
   logic                       p2_valid_ff;
   logic                       p2_last_ff;
   logic                       p2_first_ff;
   logic                       p2_use_ff;
   logic signed [POS_W-1:0]    p2_x_ff;
   logic signed [POS_W-1:0]    p2_y_ff;

   // tracking state
   logic signed [POS_W-1:0]    left_side_ff;
   logic signed [POS_W-1:0]    left_ahead_ff;
   logic signed [POS_W-1:0]    right_side_ff;
   logic signed [POS_W-1:0]    right_ahead_ff;
   logic signed [POS_W-1:0]    left_side_in;
   logic signed [POS_W-1:0]    left_ahead_in;
   logic signed [POS_W-1:0]    right_side_in;
   logic signed [POS_W-1:0]    right_ahead_in;
   logic signed [POS_W-1:0]    half_w_s;
   logic signed [POS_W-1:0]    neg_half_w_s;
   logic signed [POS_W-1:0]    depth_s;
   logic signed [POS_W-1:0]    ls_base;
   logic signed [POS_W-1:0]    la_base;
   logic signed [POS_W-1:0]    rs_base;
   logic signed [POS_W-1:0]    ra_base;
   logic                       left_hit;
   logic                       right_hit;

   // stage 3: offsets before scaling
   logic                       p3_valid_ff;
   logic signed [POS_W-1:0]    ahead_min;
   logic signed [AX_W-1:0]     ax_raw;
   logic signed [AX_W-1:0]     ay_sum;
   logic signed [AX_W-1:0]     ay_raw;
   logic                       escape;

   // stage 4: signed offsets
   logic                       p4_valid_ff;
   logic signed [AX_W-1:0]     p4_ax_ff;
   logic signed [AX_W-1:0]     p4_ay_ff;
   logic [AX_W-1:0]            ax_abs;
   logic [AX_W-1:0]            ay_abs;
   logic [AX_W:0]              my_wide;

   // stage 5: scaled magnitudes
   logic                       p5_valid_ff;
   logic                       p5_xneg_ff;
   logic                       p5_yneg_ff;
   logic [lozd_pkg::MX_W-1:0]  p5_mx_ff;
   logic [lozd_pkg::MY_W-1:0]  p5_my_ff;

   // stage 6: reciprocal products
   logic                       p6_valid_ff;
   logic                       p6_xneg_ff;
   logic                       p6_yneg_ff;
   logic [lozd_pkg::PX_W-1:0]  p6_px_ff;
   logic [lozd_pkg::PY_W-1:0]  p6_py_ff;
   logic [lozd_pkg::PX_W-lozd_pkg::DIV5_SHIFT-1:0]  qx;
   logic [lozd_pkg::PY_W-lozd_pkg::DIV10_SHIFT-1:0] qy;
   logic [OFF_W-1:0]           qx_lim;
   logic [OFF_W-1:0]           qy_lim;
   logic [OFF_W-1:0]           off_x;
   logic [OFF_W-1:0]           off_y;

   // result buffer
   logic [2*OFF_W-1:0]         fifo_ff [lozd_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff;
   logic [PTR_W-1:0]           rd_ptr_ff;
   logic [PTR_W:0]             fill_ff;
   logic [PTR_W:0]             fill_in;
   logic [PTR_W:0]             inflight_ff;
   logic [PTR_W:0]             inflight_in;
   logic                       last_accept;

   // handshakes
   assign csr_ready   = 1'b1;
   assign req_tready  = (inflight_ff < (PTR_W+1)'(lozd_pkg::FIFO_DEPTH));
   assign req_accept  = req_tvalid && req_tready;
   assign rsp_accept  = rsp_tvalid && rsp_tready;
   assign last_accept = req_accept && req_tlast;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= lozd_pkg::HALF_WIDTH_RST;
         depth_ff      <= lozd_pkg::DEPTH_RST;
         range_min_ff  <= lozd_pkg::RANGE_MIN_RST;
         range_max_ff  <= lozd_pkg::RANGE_MAX_RST;
      end else if (csr_valid && csr_ready) begin
         case (lozd_pkg::csr_index_type'(csr_index))
            lozd_pkg::CSR_HALF_WIDTH: half_width_ff <= csr_wdata;
            lozd_pkg::CSR_DEPTH:      depth_ff      <= csr_wdata;
            lozd_pkg::CSR_RANGE_MIN:  range_min_ff  <= csr_wdata;
            lozd_pkg::CSR_RANGE_MAX:  range_max_ff  <= csr_wdata;
            default: begin
               half_width_ff <= half_width_ff;
            end
         endcase
      end
   end

   // beam counter, saturating at the beam count
   always_comb begin
      beam_cnt_in = beam_cnt_ff;
      if (req_accept) begin
         if (req_tlast) begin
            beam_cnt_in = '0;
         end else if (beam_cnt_ff != CNT_W'(lozd_pkg::BEAMS)) begin
            beam_cnt_in = beam_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_cnt_ff <= '0;
      end else begin
         beam_cnt_ff <= beam_cnt_in;
      end
   end

   // window and range tests on the arriving word
   assign in_window = (int'(beam_cnt_ff) >= lozd_pkg::FIRST_BEAM) &&
                      (int'(beam_cnt_ff) <  lozd_pkg::END_BEAM) &&
                      (int'(beam_cnt_ff) <  lozd_pkg::BEAMS);
   assign in_range  = (req_tdata[lozd_pkg::RANGE_W-1:0] >= range_min_ff) &&
                      (req_tdata[lozd_pkg::RANGE_W-1:0] <= range_max_ff);
   assign rom_addr  = (int'(beam_cnt_ff) < lozd_pkg::BEAMS) ?
                      beam_cnt_ff[lozd_pkg::ADDR_W-1:0] : '0;

   // stage 1 registers and rom read
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      trig_ff <= lozd_pkg::TRIG_TAB[rom_addr];
      if (req_accept) begin
         p1_last_ff  <= req_tlast;
         p1_first_ff <= (beam_cnt_ff == '0);
         p1_use_ff   <= in_window && in_range;
         p1_range_ff <= req_tdata[lozd_pkg::RANGE_W-1:0];
      end
   end

   // rotation: x = floor(r*cos), y = floor(r*(-sin)), q15
   assign mul_x = $signed({1'b0, p1_range_ff}) * $signed(trig_ff[TRIG_W-1:0]);
   assign mul_y = $signed({1'b0, p1_range_ff}) * $signed(trig_ff[2*TRIG_W-1:TRIG_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_last_ff  <= p1_last_ff;
      p2_first_ff <= p1_first_ff;
      p2_use_ff   <= p1_use_ff;
      p2_x_ff     <= mul_x[MUL_W-1:TRIG_W-1];
      p2_y_ff     <= mul_y[MUL_W-1:TRIG_W-1];
   end

   // tracking update, reloaded from the registers on the first beam
   assign half_w_s     = $signed({{(POS_W-CFG_W){1'b0}}, half_width_ff});
   assign neg_half_w_s = -half_w_s;
   assign depth_s      = $signed({{(POS_W-CFG_W){1'b0}}, depth_ff});

   always_comb begin
      ls_base   = p2_first_ff ? half_w_s     : left_side_ff;
      la_base   = p2_first_ff ? depth_s      : left_ahead_ff;
      rs_base   = p2_first_ff ? neg_half_w_s : right_side_ff;
      ra_base   = p2_first_ff ? depth_s      : right_ahead_ff;
      left_hit  = p2_use_ff && (p2_y_ff > 0) && (p2_y_ff < half_w_s) &&
                  (p2_x_ff < depth_s);
      right_hit = p2_use_ff && !(p2_y_ff > 0) && (p2_y_ff > neg_half_w_s) &&
                  (p2_x_ff < depth_s);
      left_side_in   = (left_hit  && (p2_y_ff < ls_base)) ? p2_y_ff : ls_base;
      left_ahead_in  = (left_hit  && (p2_x_ff < la_base)) ? p2_x_ff : la_base;
      right_side_in  = (right_hit && (p2_y_ff > rs_base)) ? p2_y_ff : rs_base;
      right_ahead_in = (right_hit && (p2_x_ff < ra_base)) ? p2_x_ff : ra_base;
   end

   always_ff @(posedge clock) begin
      if (p2_valid_ff) begin
         left_side_ff   <= left_side_in;
         left_ahead_ff  <= left_ahead_in;
         right_side_ff  <= right_side_in;
         right_ahead_ff <= right_ahead_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff && p2_last_ff;
      end
   end

   // raw offsets with the escape rule when both sides are blocked
   always_comb begin
      ahead_min = (right_ahead_ff < left_ahead_ff) ? right_ahead_ff : left_ahead_ff;
      ax_raw    = {ahead_min[POS_W-1], ahead_min} -
                  $signed({{(AX_W-CFG_W){1'b0}}, depth_ff});
      ay_sum    = {left_side_ff[POS_W-1], left_side_ff} +
                  {right_side_ff[POS_W-1], right_side_ff};
      escape    = (ay_sum < lozd_pkg::NEAR_MM) &&
                  (left_side_ff < lozd_pkg::NEAR_MM) &&
                  (right_side_ff > -lozd_pkg::NEAR_MM);
      if (escape) begin
         ay_raw = (left_ahead_ff > right_ahead_ff) ? AX_W'(lozd_pkg::ESCAPE_MM) :
                                                     AX_W'(-lozd_pkg::ESCAPE_MM);
      end else begin
         ay_raw = ay_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p4_ax_ff <= ax_raw;
      p4_ay_ff <= ay_raw;
   end

   // magnitudes of ax*4 and ay*3, sign kept aside for truncation toward zero
   assign ax_abs  = p4_ax_ff[AX_W-1] ? AX_W'(-p4_ax_ff) : p4_ax_ff;
   assign ay_abs  = p4_ay_ff[AX_W-1] ? AX_W'(-p4_ay_ff) : p4_ay_ff;
   assign my_wide = {1'b0, ay_abs} + {ay_abs, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else begin
         p5_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p5_xneg_ff <= p4_ax_ff[AX_W-1];
      p5_yneg_ff <= p4_ay_ff[AX_W-1];
      p5_mx_ff   <= lozd_pkg::MX_W'({ax_abs, 2'b00});
      p5_my_ff   <= my_wide[lozd_pkg::MY_W-1:0];
   end

   // divide by 5 and by 10 through reciprocal multiplies
   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
      end else begin
         p6_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p6_xneg_ff <= p5_xneg_ff;
      p6_yneg_ff <= p5_yneg_ff;
      p6_px_ff   <= lozd_pkg::PX_W'(p5_mx_ff) * lozd_pkg::PX_W'(lozd_pkg::DIV5_MUL);
      p6_py_ff   <= lozd_pkg::PY_W'(p5_my_ff) * lozd_pkg::PY_W'(lozd_pkg::DIV10_MUL);
   end

   // quotient, limit and sign
   always_comb begin
      qx     = p6_px_ff[lozd_pkg::PX_W-1:lozd_pkg::DIV5_SHIFT];
      qy     = p6_py_ff[lozd_pkg::PY_W-1:lozd_pkg::DIV10_SHIFT];
      qx_lim = (int'(qx) > lozd_pkg::OFFSET_LIMIT) ? OFF_W'(lozd_pkg::OFFSET_LIMIT) :
                                                     OFF_W'(qx);
      qy_lim = (int'(qy) > lozd_pkg::OFFSET_LIMIT) ? OFF_W'(lozd_pkg::OFFSET_LIMIT) :
                                                     OFF_W'(qy);
      off_x  = p6_xneg_ff ? OFF_W'(-qx_lim) : qx_lim;
      off_y  = p6_yneg_ff ? OFF_W'(-qy_lim) : qy_lim;
   end

   // result buffer and pending-scan count
   always_comb begin
      fill_in     = fill_ff;
      inflight_in = inflight_ff;
      if (p6_valid_ff && !rsp_accept) begin
         fill_in = fill_ff + (PTR_W+1)'(1);
      end else if (!p6_valid_ff && rsp_accept) begin
         fill_in = fill_ff - (PTR_W+1)'(1);
      end
      if (last_accept && !rsp_accept) begin
         inflight_in = inflight_ff + (PTR_W+1)'(1);
      end else if (!last_accept && rsp_accept) begin
         inflight_in = inflight_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
         inflight_ff <= '0;
      end else begin
         fill_ff     <= fill_in;
         inflight_ff <= inflight_in;
         if (p6_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p6_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= {off_y, off_x};
      end
   end

   // result word
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = {{(lozd_pkg::RSP_TDATA_W-2*OFF_W){1'b0}}, fifo_ff[rd_ptr_ff]};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// testbench for the lidar obstacle zone detector core: beam streams, offset prediction, checks
`timescale 1ns / 100ps

module tb_top;

   import lozd_pkg::*;

   // angle constants in q30 radians
   localparam longint unsigned ANGLE_PI      = 64'd3373259426;
   localparam longint unsigned ANGLE_HALF_PI = 64'd1686629713;

   typedef struct packed {
      logic [OFF_W-1:0] x;
      logic [OFF_W-1:0] y;
   } offset_word_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   // rotation table of the predictor, q1.15
   int cos_q15 [BEAMS];
   int sin_q15 [BEAMS];

   // predictor copy of the registers and tracking state
   longint cfg_half_width;
   longint cfg_depth;
   longint cfg_range_min;
   longint cfg_range_max;
   int     scan_beam;
   longint left_side;
   longint left_ahead;
   longint right_side;
   longint right_ahead;

   offset_word_t expected_offsets [$];
   offset_word_t got_word;
   int           error_count = 0;
   int           send_gap_pct = 14;
   int           rsp_stall_pct = 76;
   int           hold_request = 0;
   int           hold_left = 0;

   lidar_obstacle_zone_detector_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial begin
      #4000000;
      $display("tb_top: errors");
      $finish;
   end

   // q30 to q15, rounded half up, limited to 0..32767
   function automatic longint round_q15(longint v);
      longint q;
      if (v < 0) begin
         q = 0;
      end else begin
         q = (v + 16384) >>> 15;
         if (q > 32767) q = 32767;
      end
      return q;
   endfunction

   // cosine and sine per beam from an eight-term series
   function automatic void build_angle_table();
      longint unsigned den;
      longint unsigned m;
      longint unsigned a;
      longint unsigned ts;
      longint unsigned tc;
      longint          n;
      longint          ss;
      longint          cc;
      longint          sq;
      longint          cq;
      bit              neg;
      bit              flip;
      int              i;
      int              k;
      den = 4 * (BEAMS - 1);
      for (i = 0; i < BEAMS; i++) begin
         n    = 3 * longint'(BEAMS - 1) - 6 * longint'(i);
         neg  = (n < 0);
         m    = neg ? -n : n;
         a    = (ANGLE_PI * m + den / 2) / den;
         flip = 1'b0;
         if (a > ANGLE_PI) a = ANGLE_PI;
         if (a > ANGLE_HALF_PI) begin
            a    = ANGLE_PI - a;
            flip = 1'b1;
         end
         ts = a;
         tc = 64'd1 << 30;
         ss = longint'(a);
         cc = longint'(64'd1 << 30);
         for (k = 1; k <= 7; k++) begin
            ts = (ts * a) >> 30;
            ts = (ts * a) >> 30;
            ts = ts / longint'((2 * k) * (2 * k + 1));
            tc = (tc * a) >> 30;
            tc = (tc * a) >> 30;
            tc = tc / longint'((2 * k - 1) * (2 * k));
            if ((k % 2) == 1) begin
               ss = ss - longint'(ts);
               cc = cc - longint'(tc);
            end else begin
               ss = ss + longint'(ts);
               cc = cc + longint'(tc);
            end
         end
         sq = round_q15(ss);
         cq = round_q15(cc);
         sin_q15[i] = neg ? -sq : sq;
         cos_q15[i] = flip ? -cq : cq;
      end
   endfunction

   function automatic longint limit_offset(longint v);
      if (v < -OFFSET_LIMIT) return -OFFSET_LIMIT;
      if (v > OFFSET_LIMIT) return OFFSET_LIMIT;
      return v;
   endfunction

   // tracking update for one beam, offset word on the last beam
   function automatic void predict_beam(input logic [15:0] range_mm, input bit last,
                                        output bit has_word, output offset_word_t word);
      longint r;
      longint x;
      longint y;
      longint ax;
      longint ay;
      r        = range_mm;
      has_word = 1'b0;
      word     = '0;
      if (scan_beam == 0) begin
         left_side   = cfg_half_width;
         left_ahead  = cfg_depth;
         right_side  = -cfg_half_width;
         right_ahead = cfg_depth;
      end
      if (scan_beam >= FIRST_BEAM && scan_beam < END_BEAM && scan_beam < BEAMS &&
          r >= cfg_range_min && r <= cfg_range_max) begin
         x = (r * cos_q15[scan_beam]) >>> 15;
         y = (-(r * sin_q15[scan_beam])) >>> 15;
         if (y > 0) begin
            if (y < cfg_half_width && x < cfg_depth) begin
               if (y < left_side) left_side = y;
               if (x < left_ahead) left_ahead = x;
            end
         end else begin
            if (-y < cfg_half_width && x < cfg_depth) begin
               if (y > right_side) right_side = y;
               if (x < right_ahead) right_ahead = x;
            end
         end
      end
      if (!last) begin
         if (scan_beam < BEAMS) scan_beam++;
      end else begin
         ax = ((right_ahead < left_ahead) ? right_ahead : left_ahead) - cfg_depth;
         ay = left_side + right_side;
         // boxed in on both sides: escape toward the side with more room ahead
         if (ay < NEAR_MM && left_side < NEAR_MM && right_side > -NEAR_MM)
            ay = (left_ahead > right_ahead) ? ESCAPE_MM : -ESCAPE_MM;
         ax        = limit_offset((ax * 4) / 5);
         ay        = limit_offset((ay * 3) / 10);
         word.x    = ax[OFF_W-1:0];
         word.y    = ay[OFF_W-1:0];
         has_word  = 1'b1;
         scan_beam = 0;
      end
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("tb_top mismatch: %s", what);
   endtask

   // one beam word, with random gaps in front
   task automatic send_beam(input logic [15:0] range_mm, input bit last);
      bit           has_word;
      offset_word_t word;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(range_mm);
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_beam(range_mm, last, has_word, word);
      if (has_word) expected_offsets.push_back(word);
   endtask

   // stop sending, wait for every offset word, let the pipeline empty
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (expected_offsets.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_HALF_WIDTH: cfg_half_width = value;
         CSR_DEPTH:      cfg_depth      = value;
         CSR_RANGE_MIN:  cfg_range_min  = value;
         CSR_RANGE_MAX:  cfg_range_max  = value;
         default: ;
      endcase
   endtask

   // all four registers, block idle
   task automatic write_settings(input logic [15:0] half_width, input logic [15:0] depth,
                                 input logic [15:0] range_min, input logic [15:0] range_max);
      wait_results_done();
      write_reg(CSR_HALF_WIDTH, half_width);
      write_reg(CSR_DEPTH, depth);
      write_reg(CSR_RANGE_MIN, range_min);
      write_reg(CSR_RANGE_MAX, range_max);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ranges biased toward the box and the range limits
   function automatic logic [15:0] pick_range();
      longint span;
      longint v;
      int     p;
      span = ((cfg_half_width > cfg_depth) ? cfg_half_width : cfg_depth) * 2 + 100;
      if (span > 65535) span = 65535;
      p = $urandom_range(99);
      if (p < 45) begin
         v = $urandom_range(0, int'(span));
      end else if (p < 55) begin
         v = (($urandom_range(1) == 1) ? cfg_range_min : cfg_range_max)
             + $urandom_range(0, 4) - 2;
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
      end else if (p < 62) begin
         v = ($urandom_range(1) == 1) ? 65535 : 0;
      end else begin
         v = $urandom_range(0, 65535);
      end
      return v[15:0];
   endfunction

   // mostly scans that reach into the window, some tiny, a few full length
   function automatic int pick_scan_length();
      int p;
      p = $urandom_range(99);
      if (p < 15) return $urandom_range(1, 10);
      if (p < 85) return $urandom_range(81, 200);
      if (p < 97) return $urandom_range(200, 400);
      return $urandom_range(900, 1100);
   endfunction

   task automatic send_scan(input int len);
      int j;
      for (j = 0; j < len; j++) send_beam(pick_range(), j == len - 1);
   endtask

   // reset values, short scans, extreme ranges and both flag values
   task automatic test_reset_defaults();
      send_beam(16'd0, 1'b1);
      send_beam(16'hFFFF, 1'b0);
      send_beam(16'd0, 1'b0);
      send_beam(16'hFFFF, 1'b1);
      send_beam(16'h5555, 1'b0);
      send_beam(16'hAAAA, 1'b1);
   endtask

   // register extremes: zero box with escape, widest box, crossed limits
   task automatic test_register_extremes();
      write_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_beam(16'd1234, 1'b1);
      send_beam(16'd0, 1'b0);
      send_beam(16'd7, 1'b1);
      write_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
      send_beam(16'hFFFF, 1'b0);
      send_beam(16'd1, 1'b1);
      write_settings(16'd5, 16'd100, 16'hFFFF, 16'd0);
      send_beam(16'd50, 1'b0);
      send_beam(16'd60, 1'b1);
      write_settings(16'd300, 16'd450, 16'd0, 16'd30000);
      send_beam(16'd200, 1'b1);
   endtask

   // one scan past the table end, with a register write in mid-scan
   task automatic test_long_scan();
      int j;
      for (j = 0; j < 1100; j++) begin
         if (j == 540)
            write_settings(16'd800, 16'd1200, cfg_range_min[15:0], cfg_range_max[15:0]);
         send_beam(pick_range(), j == 1099);
      end
   endtask

   // receiver held off while short scans keep coming, so the buffer fills
   task automatic test_backpressure();
      int s;
      wait_results_done();
      send_gap_pct = 0;
      hold_request = 400;
      for (s = 0; s < 8; s++) begin
         send_beam(pick_range(), 1'b0);
         send_beam(pick_range(), 1'b1);
      end
      req_tvalid <= 1'b0;
      while (hold_request != 0 || hold_left != 0) @(posedge clock);
      wait_results_done();
   endtask

   // random scans under one idle pattern and one register setting
   task automatic test_random_scans(input int gap_pct, input int stall_pct, input int mode);
      int     phase_items;
      int     phase_words;
      int     len;
      longint mn;
      wait_results_done();
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      case (mode)
         0: write_settings(16'd300, 16'd450, 16'd0, 16'd30000);
         1: write_settings($urandom_range(0, 2000), $urandom_range(0, 3000),
                           $urandom_range(0, 300), $urandom_range(1000, 65535));
         2: write_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
         3: begin
            mn = $urandom_range(1000, 65535);
            write_settings($urandom_range(0, 2000), $urandom_range(0, 3000),
                           mn[15:0], $urandom_range(0, int'(mn) - 1));
         end
         4: begin
            mn = $urandom_range(50, 1500);
            write_settings($urandom_range(100, 1500), $urandom_range(100, 1500),
                           mn[15:0], mn[15:0]);
         end
         default: write_settings($urandom_range(0, 20), $urandom_range(0, 20),
                                 16'd0, 16'hFFFF);
      endcase
      phase_items = 0;
      phase_words = 0;
      while (phase_items < 330 || phase_words < 7) begin
         len = pick_scan_length();
         send_scan(len);
         phase_items += len;
         phase_words++;
         // now and then the sender waits for every word to come back
         if ($urandom_range(19) == 0) wait_results_done();
      end
   endtask

   // receiver: random stalls, or a counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // offset word check against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_offsets.size() == 0) begin
            report_mismatch($sformatf("offset word %h with none expected", rsp_tdata));
         end else begin
            got_word = expected_offsets.pop_front();
            if (rsp_tdata[OFF_W-1:0] !== got_word.x)
               report_mismatch($sformatf("offset_x_mm %0d, want %0d",
                  $signed(rsp_tdata[OFF_W-1:0]), $signed(got_word.x)));
            if (rsp_tdata[2*OFF_W-1:OFF_W] !== got_word.y)
               report_mismatch($sformatf("offset_y_mm %0d, want %0d",
                  $signed(rsp_tdata[2*OFF_W-1:OFF_W]), $signed(got_word.y)));
            if (rsp_tdata[RSP_TDATA_W-1:2*OFF_W] !== '0)
               report_mismatch($sformatf("pad bits set in word %h", rsp_tdata));
         end
      end
   end

   // test sequence
   initial begin
      build_angle_table();
      cfg_half_width = 300;
      cfg_depth      = 450;
      cfg_range_min  = 0;
      cfg_range_max  = 30000;
      scan_beam      = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_long_scan();
      test_backpressure();
      test_random_scans(14, 76, 0);
      test_random_scans(14, 76, 1);
      test_random_scans(76, 14, 2);
      test_random_scans(76, 14, 3);
      test_random_scans(0, 0, 4);
      test_random_scans(0, 0, 5);
      test_random_scans(0, 0, 1);
      wait_results_done();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
